// ----- rtl/kas_pkg.sv -----
package kas_pkg;

    // keyframe table
    localparam int KEY_DEPTH = 256;
    localparam int KEY_AW    = $clog2(KEY_DEPTH);
    localparam int KEY_W     = 32;

    // first_key + key_count - 1 can reach 765, above 2^9; this width does hold a table index
    localparam int SUM_W     = 9;
    localparam int LAST_W    = (KEY_AW > SUM_W) ? KEY_AW : SUM_W;
    localparam int RED_STEPS = SUM_W;

    localparam int POS_W   = 48;
    localparam int FRAC_W  = 16;
    localparam int FRAME_W = 32;
    localparam int PROD_W  = 40;
    localparam int CFG_W   = 24;

    // remainder row: 16-bit divisor plus one bit for the shifted-in value
    localparam int DIV_W  = 16;
    localparam int REM_W  = DIV_W + 1;
    localparam int STEP_W = $clog2(FRAME_W);

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_START = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_REW   = 3'd4,
        CMD_SEEK  = 3'd5,
        CMD_PEEK  = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_SET  = 2'd0,
        KIND_DONE = 2'd1,
        KIND_PEEK = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_FIRST_KEY = 2'd0,
        CFG_KEY_COUNT = 2'd1,
        CFG_TOTAL     = 2'd2,
        CFG_RATE      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] elapsed_ms;
        logic [7:0]  key_index;
        logic [15:0] key_frame;
        logic [15:0] key_material;
        logic [15:0] target_slot;
        logic        loop_enable;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] slot;
        logic [15:0] material;
        logic [7:0]  selected_key;
    } t_out_word;

    // control broadcast to every remainder cell
    typedef struct packed {
        logic clr;
        logic step;
    } t_cell_ctl;

endpackage

// ----- rtl/kas_ram.sv -----
module kas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ----- rtl/kas_cell.sv -----
module kas_cell (
    input  logic                i_clk,
    input  kas_pkg::t_cell_ctl  i_ctl,
    input  logic                i_ge,
    input  logic                i_shift,
    input  logic                i_div_bit,
    input  logic                i_borrow,
    output logic                o_bit,
    output logic                o_borrow
);

    logic r_bit;
    logic n_bit;
    logic diff;

    // one bit slice of (shifted remainder - divisor)
    assign diff     = i_shift ^ i_div_bit ^ i_borrow;
    assign o_borrow = (~i_shift & i_div_bit) | (~(i_shift ^ i_div_bit) & i_borrow);

    always_comb begin
        n_bit = r_bit;
        if (i_ctl.clr) begin
            n_bit = 1'b0;
        end else if (i_ctl.step) begin
            n_bit = i_ge ? diff : i_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;

endmodule

// ----- rtl/kas_modrow.sv -----
module kas_modrow (
    input  logic                        i_clk,
    input  kas_pkg::t_cell_ctl          i_ctl,
    input  logic                        i_bit,
    input  logic [kas_pkg::DIV_W-1:0]   i_div,
    output logic [kas_pkg::DIV_W-1:0]   o_rem
);

    logic [kas_pkg::REM_W-1:0] cell_bit;
    logic [kas_pkg::REM_W-1:0] shift_in;
    logic [kas_pkg::REM_W-1:0] div_x;
    logic [kas_pkg::REM_W:0]   borrow;
    logic                      ge;

    assign div_x     = {1'b0, i_div};
    assign shift_in  = {cell_bit[kas_pkg::REM_W-2:0], i_bit};
    assign borrow[0] = 1'b0;
    // no borrow out of the top cell: shifted remainder >= divisor
    assign ge        = ~borrow[kas_pkg::REM_W];

    for (genvar g = 0; g < kas_pkg::REM_W; g++) begin : g_cell
        kas_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (i_ctl),
            .i_ge      (ge),
            .i_shift   (shift_in[g]),
            .i_div_bit (div_x[g]),
            .i_borrow  (borrow[g]),
            .o_bit     (cell_bit[g]),
            .o_borrow  (borrow[g+1])
        );
    end

    assign o_rem = cell_bit[kas_pkg::DIV_W-1:0];

endmodule

// ----- rtl/keyframe_animation_sequencer.sv -----
// Keyframe animation sequencer.
// Input channel (i_in_valid / o_in_ready / i_in_word) takes one command word
// per handshake; output channel (o_out_valid / i_out_ready / o_out_word)
// delivers at most one result word per command. Config port: i_cfg_we,
// i_cfg_idx, i_cfg_data; the user must write it only while the block is idle,
// which the block does not enforce; any write also clears position, active
// and looping. Write key, start, stop, rewind and seek end finish in the
// accept cycle and give no word. A tick (while active) reaches o_out_valid
// through these steps: multiply, 48-bit add, compare (tick only, a peek
// skips it), the remainder row (frame mod total_frames, one bit per cycle),
// a setup step, a downward scan of the keyframe RAM at one entry per cycle
// with a registered read, the staging register, and the output register
// once it is free.
// A play-once tick that runs out emits its finished word from the compare step.
// Items go one at a time; o_in_ready is high only when idle with none staged.
// Results sit in an output register, so a stalled receiver holds the word
// while the next command is already accepted; a new result waits in a
// staging register until the output register frees up.
// Reset (synchronous, active low) clears config to defaults, position,
// active, looping and bound slot. The keyframe RAM is not cleared.
module keyframe_animation_sequencer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  kas_pkg::t_in_word           i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output kas_pkg::t_out_word          o_out_word,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [kas_pkg::CFG_W-1:0]   i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ADD  = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_SEL  = 7'b0100000,
        S_SRCH = 7'b1000000
    } t_state;

    localparam logic [kas_pkg::STEP_W-1:0] STEP_LAST = kas_pkg::STEP_W'(kas_pkg::FRAME_W - 1);
    // index reduction runs during the first RED_STEPS divide steps
    localparam logic [kas_pkg::STEP_W-1:0] RED_FLOOR =
        kas_pkg::STEP_W'(kas_pkg::FRAME_W - kas_pkg::RED_STEPS);

    t_state r_state;

    // config
    logic [7:0]                  r_first_key;
    logic [8:0]                  r_key_count;
    logic [15:0]                 r_total;
    logic [kas_pkg::CFG_W-1:0]   r_rate;

    // animation state
    logic [kas_pkg::POS_W-1:0]   r_pos;
    logic                        r_active;
    logic                        r_looping;
    logic [15:0]                 r_bound;

    // working registers
    logic                        r_is_peek;
    logic [15:0]                 r_elapsed;
    logic [kas_pkg::PROD_W-1:0]  r_prod;
    logic [kas_pkg::FRAME_W-1:0] r_frame;
    logic [kas_pkg::STEP_W-1:0]  r_step;
    logic [kas_pkg::LAST_W-1:0]  r_v;

    // scan
    logic [kas_pkg::KEY_AW-1:0]  r_idx;
    logic [kas_pkg::KEY_AW-1:0]  r_lidx;
    logic [8:0]                  r_left;
    logic                        r_first_iss;
    logic                        r_pend;
    logic [kas_pkg::KEY_AW-1:0]  r_pidx;
    logic                        r_pfirst;
    logic                        r_plast;
    logic [15:0]                 r_fmat;

    // result staging and output register
    logic                        r_res_vld;
    logic [1:0]                  r_res_kind;
    logic [15:0]                 r_res_mat;
    logic [7:0]                  r_res_key;
    logic                        r_ovld;
    kas_pkg::t_out_word          r_out;

    logic                        in_fire;
    logic                        out_free;
    logic [8:0]                  cnt_eff;
    logic [kas_pkg::LAST_W-1:0]  sum_last;
    logic [3:0]                  red_k;
    logic [31:0]                 red_sub;
    logic                        red_ge;
    logic [kas_pkg::FRAME_W-1:0] frame_now;
    logic                        finish;
    logic                        start_div;
    logic [kas_pkg::KEY_AW-1:0]  n_idx;
    logic                        issue;
    logic                        rd_hit;
    logic                        key_we;
    logic [kas_pkg::KEY_AW-1:0]  ram_addr;
    logic [kas_pkg::KEY_W-1:0]   ram_q;
    logic [kas_pkg::DIV_W-1:0]   rem;
    kas_pkg::t_cell_ctl          cell_ctl;

    assign o_in_ready = (r_state == S_IDLE) && !r_res_vld;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_ovld || i_out_ready;

    // zero key_count counts as one keyframe
    assign cnt_eff  = (r_key_count == 9'd0) ? 9'd1 : r_key_count;
    assign sum_last = kas_pkg::LAST_W'(r_first_key) + kas_pkg::LAST_W'(cnt_eff)
                    - kas_pkg::LAST_W'(1);

    // last index mod KEY_DEPTH by restoring compare-subtract, shift 8 down to 0
    assign red_k   = 4'(r_step - RED_FLOOR);
    assign red_sub = 32'(kas_pkg::KEY_DEPTH) << red_k;
    assign red_ge  = (32'(r_v) >= red_sub);

    assign frame_now = r_pos[kas_pkg::POS_W-1:kas_pkg::FRAC_W];
    assign finish    = !r_looping && (frame_now >= kas_pkg::FRAME_W'(r_total));
    assign start_div = ((r_state == S_ADD) && r_is_peek) || ((r_state == S_CHK) && !finish);

    // table index steps downward with wrap
    assign n_idx = (r_idx == '0) ? kas_pkg::KEY_AW'(kas_pkg::KEY_DEPTH - 1)
                                 : r_idx - kas_pkg::KEY_AW'(1);
    assign issue  = (r_state == S_SRCH) && (r_left != 9'd0);
    assign rd_hit = r_frame >= kas_pkg::FRAME_W'(ram_q[31:16]);

    assign key_we   = in_fire && (i_in_word.command == kas_pkg::CMD_WRITE)
                   && (32'(i_in_word.key_index) < kas_pkg::KEY_DEPTH);
    assign ram_addr = key_we ? kas_pkg::KEY_AW'(i_in_word.key_index) : r_idx;

    kas_ram #(
        .WIDTH (kas_pkg::KEY_W),
        .DEPTH (kas_pkg::KEY_DEPTH)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_re    (issue),
        .i_addr  (ram_addr),
        .i_wdata ({i_in_word.key_frame, i_in_word.key_material}),
        .o_rdata (ram_q)
    );

    assign cell_ctl.clr  = start_div;
    assign cell_ctl.step = (r_state == S_DIV);

    // frame mod total_frames, MSB of the rotating frame register feeds the row
    kas_modrow u_mod (
        .i_clk (i_clk),
        .i_ctl (cell_ctl),
        .i_bit (r_frame[kas_pkg::FRAME_W-1]),
        .i_div (r_total),
        .o_rem (rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first_key <= 8'd0;
            r_key_count <= 9'd1;
            r_total     <= 16'd1;
            r_rate      <= '0;
            r_pos       <= '0;
            r_active    <= 1'b0;
            r_looping   <= 1'b0;
            r_bound     <= 16'd0;
            r_res_vld   <= 1'b0;
            r_ovld      <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_is_peek <= (i_in_word.command == kas_pkg::CMD_PEEK);
                        r_elapsed <= i_in_word.elapsed_ms;
                        case (i_in_word.command)
                            kas_pkg::CMD_TICK: begin
                                if (r_active) begin
                                    r_state <= S_MUL;
                                end
                            end
                            kas_pkg::CMD_START: begin
                                r_bound   <= i_in_word.target_slot;
                                r_looping <= i_in_word.loop_enable;
                                r_active  <= 1'b1;
                            end
                            kas_pkg::CMD_STOP: begin
                                r_active  <= 1'b0;
                                r_looping <= 1'b0;
                            end
                            kas_pkg::CMD_REW: begin
                                r_pos <= '0;
                            end
                            kas_pkg::CMD_SEEK: begin
                                if (r_total == 16'd0) begin
                                    r_pos <= '0;
                                end else begin
                                    r_pos <= kas_pkg::POS_W'({r_total - 16'd1, 16'd0});
                                end
                            end
                            kas_pkg::CMD_PEEK: begin
                                r_state <= S_MUL;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= kas_pkg::PROD_W'(r_rate) * kas_pkg::PROD_W'(r_elapsed);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (r_is_peek) begin
                        r_frame <= kas_pkg::FRAME_W'(r_prod[kas_pkg::PROD_W-1:kas_pkg::FRAC_W]);
                        r_v     <= sum_last;
                        r_step  <= STEP_LAST;
                        r_state <= S_DIV;
                    end else begin
                        r_pos   <= r_pos + kas_pkg::POS_W'(r_prod);
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (finish) begin
                        // play-once ran out: stop, rewind, report
                        r_active   <= 1'b0;
                        r_looping  <= 1'b0;
                        r_pos      <= '0;
                        r_res_vld  <= 1'b1;
                        r_res_kind <= kas_pkg::KIND_DONE;
                        r_res_mat  <= 16'd0;
                        r_res_key  <= 8'd0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_frame <= frame_now;
                        r_v     <= sum_last;
                        r_step  <= STEP_LAST;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // rotate so the frame is intact after the last step
                    r_frame <= {r_frame[kas_pkg::FRAME_W-2:0], r_frame[kas_pkg::FRAME_W-1]};
                    if (r_step >= RED_FLOOR && red_ge) begin
                        r_v <= r_v - kas_pkg::LAST_W'(red_sub);
                    end
                    if (r_step == '0) begin
                        r_state <= S_SEL;
                    end else begin
                        r_step <= r_step - kas_pkg::STEP_W'(1);
                    end
                end
                S_SEL: begin
                    // zero total_frames: frame used as is
                    if (r_total != 16'd0) begin
                        r_frame <= kas_pkg::FRAME_W'(rem);
                    end
                    r_idx       <= kas_pkg::KEY_AW'(r_v);
                    r_lidx      <= kas_pkg::KEY_AW'(r_v);
                    r_left      <= cnt_eff;
                    r_first_iss <= 1'b1;
                    r_pend      <= 1'b0;
                    r_state     <= S_SRCH;
                end
                S_SRCH: begin
                    // issue side: one read per cycle, walking down
                    r_pend <= issue;
                    if (issue) begin
                        r_pidx      <= r_idx;
                        r_pfirst    <= r_first_iss;
                        r_plast     <= (r_left == 9'd1);
                        r_first_iss <= 1'b0;
                        r_idx       <= n_idx;
                        r_left      <= r_left - 9'd1;
                    end
                    // compare side: data of last cycle's read
                    if (r_pend) begin
                        if (r_pfirst) begin
                            r_fmat <= ram_q[15:0];
                        end
                        if (rd_hit || r_plast) begin
                            r_res_vld  <= 1'b1;
                            r_res_kind <= r_is_peek ? kas_pkg::KIND_PEEK : kas_pkg::KIND_SET;
                            r_pend     <= 1'b0;
                            r_state    <= S_IDLE;
                            if (rd_hit) begin
                                r_res_mat <= ram_q[15:0];
                                r_res_key <= 8'(r_pidx);
                            end else begin
                                // nothing qualified: last keyframe
                                r_res_mat <= r_pfirst ? ram_q[15:0] : r_fmat;
                                r_res_key <= 8'(r_lidx);
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // staged result into the output register
            if (r_res_vld && out_free) begin
                r_res_vld <= 1'b0;
                r_ovld    <= 1'b1;
                r_out     <= '{kind: r_res_kind, slot: r_bound,
                               material: r_res_mat, selected_key: r_res_key};
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end

            if (i_cfg_we) begin
                case (kas_pkg::t_cfg_idx'(i_cfg_idx))
                    kas_pkg::CFG_FIRST_KEY: r_first_key <= i_cfg_data[7:0];
                    kas_pkg::CFG_KEY_COUNT: r_key_count <= i_cfg_data[8:0];
                    kas_pkg::CFG_TOTAL:     r_total     <= i_cfg_data[15:0];
                    kas_pkg::CFG_RATE:      r_rate      <= i_cfg_data;
                    default: begin
                    end
                endcase
                r_pos     <= '0;
                r_active  <= 1'b0;
                r_looping <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_word  = r_out;

endmodule
